>>> src/w2m8_pkg.sv
`timescale 1ns / 1ps

package w2m8_pkg;

    // Largest channel count that the decoder accepts in a data chunk.
    localparam int MAX_CHANNELS = 8;

    // Channel count as held by the frame logic and the divider.
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    // Magnitude of a frame sum, and the signed sum itself.
    localparam int MAG_W = $clog2(128 * MAX_CHANNELS) + 1;
    localparam int SUM_W = MAG_W + 1;
    // Byte counter shared by the chunk header and the frame assembly.
    localparam int BIF_W = (CH_W + 1 > 4) ? CH_W + 1 : 4;
    // Iteration counter of the divider.
    localparam int CNT_W = $clog2(MAG_W + 1);
    // File position only matters up to the minimum file length.
    localparam int POS_W = 6;
    // Offset inside a chunk body, saturating once past the fmt fields.
    localparam int OFF_W = 5;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [POS_W-1:0] POS_RIFF_END = POS_W'(3);
    localparam logic [POS_W-1:0] POS_WAVE_END = POS_W'(11);
    localparam logic [POS_W-1:0] POS_MIN_FILE = POS_W'(44);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    localparam logic [BIF_W-1:0] TAG_LEN = BIF_W'(4);
    localparam logic [BIF_W-1:0] HDR_LEN = BIF_W'(8);

    localparam logic [OFF_W-1:0] OFF_CH_LO   = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_CH_HI   = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_RATE_LO = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFF_RATE_HI = OFF_W'(7);
    localparam logic [OFF_W-1:0] OFF_BITS_LO = OFF_W'(14);
    localparam logic [OFF_W-1:0] OFF_BITS_HI = OFF_W'(15);
    localparam logic [OFF_W-1:0] OFF_SAT     = OFF_W'(16);

    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [15:0] BITS_8       = 16'd8;
    localparam logic [15:0] BITS_16      = 16'd16;
    localparam logic [7:0]  SAMPLE_BIAS  = 8'h80;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                    frame_done;
        logic signed [SUM_W-1:0] frame_sum;
        logic [CH_W-1:0]         channels;
    } w2m8_frame_t;

    typedef struct packed {
        logic        status_ok;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] sample_rate;
        logic [31:0] frame_count;
    } w2m8_summary_t;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] sample;
        logic              status_ok;
        logic [15:0]       channel_count;
        logic [15:0]       sample_bits;
        logic [31:0]       sample_rate;
        logic [31:0]       frame_count;
        logic              run_last;
    } w2m8_result_t;

endpackage

>>> src/w2m8_in_if.sv
`timescale 1ns / 1ps

interface w2m8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       final_byte;

    modport source (output valid, output file_byte, output final_byte, input ready);
    modport sink   (input valid, input file_byte, input final_byte, output ready);
endinterface

>>> src/w2m8_out_if.sv
`timescale 1ns / 1ps

interface w2m8_out_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [7:0] sample;
    logic              status_ok;
    logic [15:0]       channel_count;
    logic [15:0]       sample_bits;
    logic [31:0]       sample_rate;
    logic [31:0]       frame_count;
    logic              run_last;

    modport source (
        output valid, output kind, output sample, output status_ok,
        output channel_count, output sample_bits, output sample_rate,
        output frame_count, output run_last, input ready
    );
    modport sink (
        input valid, input kind, input sample, input status_ok,
        input channel_count, input sample_bits, input sample_rate,
        input frame_count, input run_last, output ready
    );
endinterface

>>> src/w2m8_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncating toward zero.
module w2m8_div
    import w2m8_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CH_W-1:0]         divisor,
    output logic                    last_step,
    output logic signed [7:0]       quotient
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [CH_W-1:0]  div_reg, div_next;
    logic [CH_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;

    logic [SUM_W-1:0] neg_dividend;
    logic [MAG_W-1:0] mag;
    logic [CH_W:0]    trial;
    logic [CH_W:0]    diff;
    logic [MAG_W-1:0] quo_neg;

    always_comb
    begin
        neg_dividend = -dividend;
        mag   = dividend[SUM_W-1] ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
        trial = {rem_reg, quo_reg[MAG_W-1]};
        diff  = trial - {1'b0, div_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            neg_next  = dividend[SUM_W-1];
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = mag;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[CH_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CH_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign last_step = busy_reg && (cnt_reg == CNT_W'(1));
    assign quo_neg   = -quo_reg;
    assign quotient  = neg_reg ? quo_neg[7:0] : quo_reg[7:0];

endmodule

>>> src/w2m8_parser.sv
`timescale 1ns / 1ps

// Byte-level RIFF/WAVE walker: tags, chunk headers, fmt fields and frame sums.
module w2m8_parser
    import w2m8_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          clear,
    input  logic [7:0]    file_byte,
    output w2m8_frame_t   frame,
    output w2m8_summary_t summary
);

    typedef enum logic [4:0] {
        PH_RIFF   = 5'b00001,
        PH_HDR    = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_IGNORE = 5'b10000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    good_reg, good_next;
    logic [31:0]             tag_reg, tag_next;
    logic [31:0]             size_reg, size_next;
    logic [32:0]             remain_reg, remain_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [15:0]             fmt_ch_reg, fmt_ch_next;
    logic [31:0]             fmt_rate_reg, fmt_rate_next;
    logic [15:0]             fmt_bits_reg, fmt_bits_next;
    logic [15:0]             pend_ch_reg, pend_ch_next;
    logic [31:0]             pend_rate_reg, pend_rate_next;
    logic [7:0]              pend_lo_reg, pend_lo_next;
    logic [BIF_W-1:0]        bif_reg, bif_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [31:0]             frames_reg, frames_next;
    logic                    fail_reg, fail_next;
    logic                    got_reg, got_next;

    logic [31:0]             tag_shift;
    logic [31:0]             new_size;
    logic [32:0]             remain_dec;
    logic [BIF_W-1:0]        bif_inc;
    logic [BIF_W-1:0]        frame_bytes;
    logic [CH_W-1:0]         ch_narrow;
    logic [7:0]              signed_byte;
    logic signed [SUM_W-1:0] add_val;
    logic signed [SUM_W-1:0] sum_acc;
    logic                    is_fmt;
    logic                    fmt_bad;
    logic                    frame_done;

    always_comb
    begin
        tag_shift  = {tag_reg[23:0], file_byte};
        remain_dec = remain_reg - 33'd1;
        bif_inc    = bif_reg + 1'b1;
        ch_narrow  = fmt_ch_reg[CH_W-1:0];
        frame_bytes = (fmt_bits_reg == BITS_16) ? BIF_W'({ch_narrow, 1'b0})
                                                : BIF_W'(ch_narrow);
        is_fmt     = (tag_reg == TAG_FMT) && (size_reg >= FMT_MIN_SIZE);

        new_size = size_reg;
        if (bif_reg < TAG_LEN)
        begin
            if (bif_reg == '0)
            begin
                new_size = '0;
            end
        end
        else
        begin
            new_size[8*bif_reg[1:0] +: 8] = file_byte;
        end

        fmt_bad = (fmt_rate_reg == '0) || (fmt_ch_reg == '0)
               || (fmt_ch_reg > 16'(MAX_CHANNELS))
               || ((fmt_bits_reg != BITS_8) && (fmt_bits_reg != BITS_16))
               || (new_size == '0);

        // A 16-bit channel gives its high byte, an 8-bit one its value less 128.
        if (fmt_bits_reg == BITS_16)
        begin
            signed_byte = bif_reg[0] ? file_byte : 8'h00;
        end
        else
        begin
            signed_byte = file_byte ^ SAMPLE_BIAS;
        end
        add_val = {{(SUM_W-8){signed_byte[7]}}, signed_byte};
        sum_acc = sum_reg + add_val;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        good_next      = good_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        remain_next    = remain_reg;
        off_next       = off_reg;
        fmt_ch_next    = fmt_ch_reg;
        fmt_rate_next  = fmt_rate_reg;
        fmt_bits_next  = fmt_bits_reg;
        pend_ch_next   = pend_ch_reg;
        pend_rate_next = pend_rate_reg;
        pend_lo_next   = pend_lo_reg;
        bif_next       = bif_reg;
        sum_next       = sum_reg;
        frames_next    = frames_reg;
        fail_next      = fail_reg;
        got_next       = got_reg;
        frame_done     = 1'b0;

        if (clear)
        begin
            phase_next     = PH_RIFF;
            pos_next       = '0;
            good_next      = 1'b1;
            tag_next       = '0;
            size_next      = '0;
            remain_next    = '0;
            off_next       = '0;
            fmt_ch_next    = '0;
            fmt_rate_next  = '0;
            fmt_bits_next  = '0;
            pend_ch_next   = '0;
            pend_rate_next = '0;
            pend_lo_next   = '0;
            bif_next       = '0;
            sum_next       = '0;
            frames_next    = '0;
            fail_next      = 1'b0;
            got_next       = 1'b0;
        end
        else if (step)
        begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

            unique case (phase_reg)
                PH_RIFF:
                begin
                    tag_next = tag_shift;
                    if ((pos_reg == POS_RIFF_END) && (tag_shift != TAG_RIFF))
                    begin
                        good_next = 1'b0;
                    end
                    if (pos_reg == POS_WAVE_END)
                    begin
                        bif_next = '0;
                        if ((tag_shift != TAG_WAVE) || !good_reg)
                        begin
                            good_next  = 1'b0;
                            phase_next = PH_IGNORE;
                        end
                        else
                        begin
                            phase_next = PH_HDR;
                        end
                    end
                end
                PH_HDR:
                begin
                    if (bif_reg < TAG_LEN)
                    begin
                        tag_next = tag_shift;
                    end
                    size_next = new_size;
                    if (bif_inc >= HDR_LEN)
                    begin
                        bif_next = '0;
                        if (tag_reg == TAG_DATA)
                        begin
                            if (fmt_bad)
                            begin
                                fail_next  = 1'b1;
                                phase_next = PH_IGNORE;
                            end
                            else
                            begin
                                remain_next = {1'b0, new_size};
                                sum_next    = '0;
                                phase_next  = PH_DATA;
                            end
                        end
                        else
                        begin
                            pend_ch_next   = '0;
                            pend_rate_next = '0;
                            pend_lo_next   = '0;
                            off_next       = '0;
                            remain_next    = {1'b0, new_size} + {32'd0, new_size[0]};
                            phase_next     = (new_size == '0) ? PH_HDR : PH_BODY;
                        end
                    end
                    else
                    begin
                        bif_next = bif_inc;
                    end
                end
                PH_BODY:
                begin
                    if (is_fmt)
                    begin
                        if (off_reg == OFF_CH_LO)
                        begin
                            pend_ch_next = {8'h00, file_byte};
                        end
                        else if (off_reg == OFF_CH_HI)
                        begin
                            pend_ch_next[15:8] = file_byte;
                        end
                        else if ((off_reg >= OFF_RATE_LO) && (off_reg <= OFF_RATE_HI))
                        begin
                            pend_rate_next[8*off_reg[1:0] +: 8] = file_byte;
                        end
                        else if (off_reg == OFF_BITS_LO)
                        begin
                            pend_lo_next = file_byte;
                        end
                        else if (off_reg == OFF_BITS_HI)
                        begin
                            fmt_ch_next   = pend_ch_reg;
                            fmt_rate_next = pend_rate_reg;
                            fmt_bits_next = {file_byte, pend_lo_reg};
                        end
                    end
                    off_next    = (off_reg == OFF_SAT) ? off_reg : off_reg + 1'b1;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_HDR;
                        bif_next   = '0;
                    end
                end
                PH_DATA:
                begin
                    got_next = 1'b1;
                    if (bif_inc >= frame_bytes)
                    begin
                        frame_done  = 1'b1;
                        frames_next = frames_reg + 32'd1;
                        sum_next    = '0;
                        bif_next    = '0;
                    end
                    else
                    begin
                        sum_next = sum_acc;
                        bif_next = bif_inc;
                    end
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_IGNORE;
                    end
                end
                PH_IGNORE:
                begin
                end
                default:
                begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            pos_reg       <= '0;
            good_reg      <= 1'b1;
            tag_reg       <= '0;
            size_reg      <= '0;
            remain_reg    <= '0;
            off_reg       <= '0;
            fmt_ch_reg    <= '0;
            fmt_rate_reg  <= '0;
            fmt_bits_reg  <= '0;
            pend_ch_reg   <= '0;
            pend_rate_reg <= '0;
            pend_lo_reg   <= '0;
            bif_reg       <= '0;
            sum_reg       <= '0;
            frames_reg    <= '0;
            fail_reg      <= 1'b0;
            got_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            good_reg      <= good_next;
            tag_reg       <= tag_next;
            size_reg      <= size_next;
            remain_reg    <= remain_next;
            off_reg       <= off_next;
            fmt_ch_reg    <= fmt_ch_next;
            fmt_rate_reg  <= fmt_rate_next;
            fmt_bits_reg  <= fmt_bits_next;
            pend_ch_reg   <= pend_ch_next;
            pend_rate_reg <= pend_rate_next;
            pend_lo_reg   <= pend_lo_next;
            bif_reg       <= bif_next;
            sum_reg       <= sum_next;
            frames_reg    <= frames_next;
            fail_reg      <= fail_next;
            got_reg       <= got_next;
        end
    end

    assign frame.frame_done = frame_done;
    assign frame.frame_sum  = sum_acc;
    assign frame.channels   = ch_narrow;

    assign summary.status_ok     = good_reg && (pos_reg >= POS_MIN_FILE) && !fail_reg
                                   && got_reg;
    assign summary.channel_count = fmt_ch_reg;
    assign summary.sample_bits   = fmt_bits_reg;
    assign summary.sample_rate   = fmt_rate_reg;
    assign summary.frame_count   = frames_reg;

endmodule

>>> src/wav_to_mono8_decoder.sv
`timescale 1ns / 1ps

// Channel         Direction  Carries
// file_stream     in         file_byte (8), final_byte (1): one byte of the WAV file
// result_stream   out        kind, sample, status_ok, channel_count, sample_bits,
//                            sample_rate, frame_count, run_last
//
// A byte that completes no frame is accepted in ST_IDLE and parsed in ST_PARSE.
// A byte that completes a frame then runs the bit-serial divider that averages the
// channels in ST_DIV and loads its sample request in ST_SAMPLE; a final byte then
// goes on to ST_SUMMARY for its summary request.
// rst_n is asynchronous and active low; after the summary of a final byte the
// parser returns to its reset state and the next byte starts a new file.
// A stalled result request is held in the output register; the block takes the next
// byte while it waits, and stalls only when it has a further request to load.

module wav_to_mono8_decoder
    import w2m8_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    w2m8_in_if.sink           file_stream,
    w2m8_out_if.source        result_stream
);

    // Sequencer: one byte is parsed at a time, and only a byte that closes a
    // frame runs the shared divider.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_PARSE   = 5'b00010,
        ST_DIV     = 5'b00100,
        ST_SAMPLE  = 5'b01000,
        ST_SUMMARY = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic          out_valid_reg, out_valid_next;
    w2m8_result_t  result_reg, result_next;

    logic              in_accept;
    logic              slot_free;
    logic              step;
    logic              clear;
    logic              div_start;
    logic              div_last;
    logic signed [7:0] quotient;
    w2m8_frame_t       frame;
    w2m8_summary_t     summary;

    // The parser holds all file state and performs one byte of work per step.
    w2m8_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .clear     (clear),
        .file_byte (byte_reg),
        .frame     (frame),
        .summary   (summary)
    );

    // The divider forms the channel average, truncating toward zero.
    w2m8_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (frame.frame_sum),
        .divisor   (frame.channels),
        .last_step (div_last),
        .quotient  (quotient)
    );

    assign file_stream.ready = (state_reg == ST_IDLE);
    assign in_accept = file_stream.valid && file_stream.ready;
    // The output register can take a new request when empty or being drained.
    assign slot_free = !out_valid_reg || result_stream.ready;
    assign step      = (state_reg == ST_PARSE);
    assign div_start = step && frame.frame_done;

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !result_stream.ready;
        clear          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    byte_next  = file_stream.file_byte;
                    last_next  = file_stream.final_byte;
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE:
            begin
                if (frame.frame_done)
                begin
                    state_next = ST_DIV;
                end
                else if (last_reg)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    result_next.kind     = KIND_SAMPLE;
                    result_next.sample   = quotient;
                    // The sample is the last request of this byte unless a summary follows.
                    result_next.run_last = !last_reg;
                    state_next = last_reg ? ST_SUMMARY : ST_IDLE;
                end
            end
            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    result_next.kind          = KIND_SUMMARY;
                    result_next.status_ok     = summary.status_ok;
                    result_next.channel_count = summary.channel_count;
                    result_next.sample_bits   = summary.sample_bits;
                    result_next.sample_rate   = summary.sample_rate;
                    result_next.frame_count   = summary.frame_count;
                    result_next.run_last      = 1'b1;
                    // The summary is captured, so the parser can start a new file.
                    clear      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        result_reg <= result_next;
    end

    assign result_stream.valid         = out_valid_reg;
    assign result_stream.kind          = result_reg.kind;
    assign result_stream.sample        = result_reg.sample;
    assign result_stream.status_ok     = result_reg.status_ok;
    assign result_stream.channel_count = result_reg.channel_count;
    assign result_stream.sample_bits   = result_reg.sample_bits;
    assign result_stream.sample_rate   = result_reg.sample_rate;
    assign result_stream.frame_count   = result_reg.frame_count;
    assign result_stream.run_last      = result_reg.run_last;

endmodule

>>> src/w2m8_checker.sv
`timescale 1ns / 1ps

module w2m8_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_kind,
    input logic signed [7:0] out_sample,
    input logic              out_run_last
);

    // Bytes are taken one at a time: an accepted byte is always worked on first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("byte accepted while the previous one is still in work");

    // A summary always closes the requests of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind) |-> out_run_last)
        else $error("summary request without run_last");

    // A new request is only loaded while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("request loaded while a byte could be accepted");

    // A stalled request holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_kind) && $stable(out_sample) && $stable(out_run_last)))
        else $error("stalled request changed");

endmodule

bind wav_to_mono8_decoder w2m8_checker u_w2m8_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (file_stream.valid),
    .in_ready     (file_stream.ready),
    .out_valid    (result_stream.valid),
    .out_ready    (result_stream.ready),
    .out_kind     (result_stream.kind),
    .out_sample   (result_stream.sample),
    .out_run_last (result_stream.run_last)
);

>>> tb/sv/tb_wav_to_mono8_decoder.sv
`timescale 1ns / 1ps

module tb_wav_to_mono8_decoder;
    import w2m8_pkg::*;

    // A chunk tag that the decoder has no special meaning for, and the
    // format code written into the first two bytes of each fmt body long enough to hold it.
    localparam logic [31:0] TAG_LIST   = 32'h4C49_5354;
    localparam logic [15:0] FORMAT_PCM = 16'd1;

    // The receiver holds off for this long once in the run, which is far
    // longer than the block can buffer, so its input must stall.
    localparam int BACKLOG_CYCLES = 300;
    // Cycles with no request taken on either side before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 3000;
    // The wait after the last result before the decoder counts as idle, sized
    // with a margin from the work that a framed final byte takes.
    localparam int SETTLE_CYCLES  = 2 * (MAG_W + 4);

    typedef enum logic [2:0] {
        PARSE_RIFF,
        PARSE_HDR,
        PARSE_BODY,
        PARSE_DATA,
        PARSE_IDLE
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    w2m8_in_if  file_stream ();
    w2m8_out_if result_stream ();

    wav_to_mono8_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_stream   (file_stream),
        .result_stream (result_stream)
    );

    always #10 clk = ~clk;

    // Results that the decoder still owes, oldest first.
    w2m8_result_t decoded_due[$];
    w2m8_result_t owed;
    int           mismatches = 0;

    // The file being assembled by the test tasks before it is sent.
    logic [7:0] wav_bytes[$];

    // Idling controls: a gap or a stall starts with odds of one in the value
    // given, and zero turns idling off on that side.
    int gap_odds   = 0;
    int stall_odds = 0;
    bit backlog_hold = 1'b0;
    int quiet_cycles = 0;

    // Our own copy of the parser state.
    parse_phase_t parse_phase;
    logic [31:0]  pos_count;
    logic         tags_good;
    logic [31:0]  cur_tag;
    logic [31:0]  cur_size;
    logic [32:0]  body_left;
    logic [15:0]  fmt_ch;
    logic [31:0]  fmt_rt;
    logic [15:0]  fmt_bt;
    int           frame_pos;
    int           acc;
    logic [31:0]  frames_out;
    logic         bad_format;
    logic [15:0]  new_ch;
    logic [31:0]  new_rt;
    logic [7:0]   new_bits_lo;
    logic         data_seen;

    function automatic void clear_parser();
        parse_phase = PARSE_RIFF;
        pos_count   = '0;
        tags_good   = 1'b1;
        cur_tag     = '0;
        cur_size    = '0;
        body_left   = '0;
        fmt_ch      = '0;
        fmt_rt      = '0;
        fmt_bt      = '0;
        frame_pos   = 0;
        acc         = 0;
        frames_out  = '0;
        bad_format  = 1'b0;
        new_ch      = '0;
        new_rt      = '0;
        new_bits_lo = '0;
        data_seen   = 1'b0;
    endfunction

    // Advances the parser by one file byte and queues the sample and the
    // end-of-file summary that the byte gives rise to.
    function automatic void decode_wav_byte(logic [7:0] b, logic fin);
        w2m8_result_t r;
        logic [32:0]  off;
        int           frame_bytes;
        int           avg;
        bit           made_sample;
        made_sample = 1'b0;
        r = '0;
        case (parse_phase)
            PARSE_RIFF:
            begin
                cur_tag = {cur_tag[23:0], b};
                if (pos_count == 32'(POS_RIFF_END) && cur_tag != TAG_RIFF)
                    tags_good = 1'b0;
                if (pos_count == 32'(POS_WAVE_END))
                begin
                    if (cur_tag != TAG_WAVE)
                        tags_good = 1'b0;
                    parse_phase = tags_good ? PARSE_HDR : PARSE_IDLE;
                    frame_pos = 0;
                end
            end
            PARSE_HDR:
            begin
                if (frame_pos < 4)
                begin
                    cur_tag = {cur_tag[23:0], b};
                    if (frame_pos == 0)
                        cur_size = '0;
                end
                else
                    cur_size = cur_size | (32'(b) << (8 * (frame_pos - 4)));
                frame_pos++;
                if (frame_pos >= 8)
                begin
                    frame_pos = 0;
                    if (cur_tag == TAG_DATA)
                    begin
                        if (fmt_rt == 0 || fmt_ch == 0 || fmt_ch > MAX_CHANNELS ||
                            (fmt_bt != BITS_8 && fmt_bt != BITS_16) || cur_size == 0)
                        begin
                            bad_format  = 1'b1;
                            parse_phase = PARSE_IDLE;
                        end
                        else
                        begin
                            body_left   = {1'b0, cur_size};
                            acc         = 0;
                            parse_phase = PARSE_DATA;
                        end
                    end
                    else
                    begin
                        new_ch      = '0;
                        new_rt      = '0;
                        new_bits_lo = '0;
                        body_left   = {1'b0, cur_size} + cur_size[0];
                        parse_phase = (body_left == 0) ? PARSE_HDR : PARSE_BODY;
                    end
                end
            end
            PARSE_BODY:
            begin
                off = {1'b0, cur_size} + cur_size[0] - body_left;
                if (cur_tag == TAG_FMT && cur_size >= FMT_MIN_SIZE)
                begin
                    if (off == 2)
                        new_ch[7:0] = b;
                    else if (off == 3)
                        new_ch[15:8] = b;
                    else if (off >= 4 && off <= 7)
                        new_rt = new_rt | (32'(b) << (8 * (off - 4)));
                    else if (off == 14)
                        new_bits_lo = b;
                    else if (off == 15)
                    begin
                        fmt_ch = new_ch;
                        fmt_rt = new_rt;
                        fmt_bt = {b, new_bits_lo};
                    end
                end
                body_left--;
                if (body_left == 0)
                begin
                    parse_phase = PARSE_HDR;
                    frame_pos = 0;
                end
            end
            PARSE_DATA:
            begin
                frame_bytes = int'(fmt_bt / 8) * int'(fmt_ch);
                data_seen = 1'b1;
                // A 16-bit channel counts only through its high byte.
                if (fmt_bt == BITS_16)
                begin
                    if (frame_pos % 2 == 1)
                        acc += int'($signed(b));
                end
                else
                    acc += int'(b) - int'(SAMPLE_BIAS);
                frame_pos++;
                if (frame_pos >= frame_bytes)
                begin
                    avg = acc / int'(fmt_ch);
                    r.kind = KIND_SAMPLE;
                    r.sample = avg[7:0];
                    made_sample = 1'b1;
                    frames_out++;
                    acc = 0;
                    frame_pos = 0;
                end
                body_left--;
                if (body_left == 0)
                    parse_phase = PARSE_IDLE;
            end
            default:
            begin
            end
        endcase

        if (pos_count != '1)
            pos_count++;

        if (made_sample)
        begin
            r.run_last = !fin;
            decoded_due.push_back(r);
        end
        if (fin)
        begin
            r = '0;
            r.kind          = KIND_SUMMARY;
            r.status_ok     = tags_good && pos_count >= 32'(POS_MIN_FILE) &&
                              !bad_format && data_seen;
            r.channel_count = fmt_ch;
            r.sample_bits   = fmt_bt;
            r.sample_rate   = fmt_rt;
            r.frame_count   = frames_out;
            r.run_last      = 1'b1;
            decoded_due.push_back(r);
            clear_parser();
        end
    endfunction

    // File assembly.
    function automatic void put_byte(logic [7:0] b);
        wav_bytes.push_back(b);
    endfunction

    function automatic void put_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            put_byte(v[8 * i +: 8]);
    endfunction

    // Tags go out first character first, so the first byte is the MSB.
    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            put_byte(t[8 * i +: 8]);
    endfunction

    function automatic void put_riff_head();
        put_tag(TAG_RIFF);
        put_le32($urandom);
        put_tag(TAG_WAVE);
    endfunction

    // A chunk with a random body, padded to an even length.
    function automatic void put_chunk(logic [31:0] tag, int size);
        put_tag(tag);
        put_le32(size);
        repeat (size + size % 2)
            put_byte(8'($urandom));
    endfunction

    // A fmt chunk of the given size; bytes past the sixteen standard ones
    // are random, and a short size cuts the standard fields off.
    function automatic void put_fmt(logic [15:0] ch, logic [15:0] bits, logic [31:0] rate,
                                    int size);
        logic [127:0] fields;
        fields = {bits, 16'(ch * bits / 8), 32'(rate * ch * bits / 8), rate, ch, FORMAT_PCM};
        put_tag(TAG_FMT);
        put_le32(size);
        for (int i = 0; i < size + size % 2; i++)
            put_byte(i < 16 ? fields[8 * i +: 8] : 8'($urandom));
    endfunction

    function automatic void put_data(logic [31:0] declared, int n);
        put_tag(TAG_DATA);
        put_le32(declared);
        repeat (n)
            put_byte(8'($urandom));
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 6;
            default: return 25;
        endcase
    endfunction

    // Offers one byte and waits for the decoder to take the request. The
    // valid stays high into the next call unless a gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            file_stream.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        file_stream.valid      <= 1'b1;
        file_stream.file_byte  <= b;
        file_stream.final_byte <= fin;
        @(posedge clk);
        while (!file_stream.ready)
            @(posedge clk);
        decode_wav_byte(b, fin);
    endtask

    task automatic send_file();
        foreach (wav_bytes[i])
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        wav_bytes.delete();
    endtask

    // Drops valid, then waits for every owed result and a little beyond.
    task automatic drain_decoder();
        file_stream.valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Full-scale samples in both widths, truncation of a negative average
    // toward zero, the widest channel count, the largest rate, a partial
    // last frame and bytes after the data chunk.
    task automatic test_extreme_samples();
        put_riff_head();
        put_fmt(1, BITS_16, 32'hFFFF_FFFF, 16);
        put_data(9, 0);
        put_byte(8'h00); put_byte(8'h80);
        put_byte(8'hFF); put_byte(8'h7F);
        put_byte(8'h34); put_byte(8'h00);
        put_byte(8'h12); put_byte(8'hFF);
        put_byte(8'h55);
        send_file();

        put_riff_head();
        put_fmt(2, BITS_8, 32'd1, 16);
        put_data(8, 0);
        put_byte(8'h00); put_byte(8'h00);
        put_byte(8'hFF); put_byte(8'hFF);
        put_byte(8'h00); put_byte(8'h01);
        put_byte(8'h80); put_byte(8'h7F);
        repeat (3) put_byte(8'($urandom));
        send_file();

        put_riff_head();
        put_fmt(MAX_CHANNELS, BITS_16, 32'd44100, 16);
        put_data(MAX_CHANNELS * 8, MAX_CHANNELS * 8);
        send_file();
        drain_decoder();
    endtask

    // Chunk walking: an odd chunk with its pad byte, an empty chunk, a fmt
    // too short to count, and a later fmt with extra bytes that replaces an
    // earlier one.
    task automatic test_chunk_walk();
        put_riff_head();
        put_chunk(TAG_LIST, 3);
        put_chunk(TAG_LIST, 0);
        put_fmt(3, BITS_8, 32'd8000, 12);
        put_fmt(1, BITS_16, 32'd22050, 16);
        put_fmt(3, BITS_8, 32'd8000, 19);
        put_data(6, 6);
        send_file();
        drain_decoder();
    endtask

    // Each way the format can be refused when the data chunk begins.
    task automatic test_format_faults();
        put_riff_head();
        put_data(4, 4);
        send_file();

        put_riff_head();
        put_fmt(MAX_CHANNELS + 1, BITS_8, 32'd8000, 16);
        put_data(4, 4);
        send_file();

        put_riff_head();
        put_fmt(0, BITS_8, 32'd8000, 16);
        put_data(4, 4);
        send_file();

        put_riff_head();
        put_fmt(1, 16'd24, 32'd8000, 16);
        put_data(6, 6);
        send_file();

        put_riff_head();
        put_fmt(1, BITS_8, 32'd0, 16);
        put_data(4, 4);
        send_file();

        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(0, 4);
        send_file();
        drain_decoder();
    endtask

    // A broken RIFF tag and a broken WAVE tag in otherwise sound files.
    task automatic test_bad_tags();
        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(4, 4);
        wav_bytes[0] = wav_bytes[0] ^ 8'h01;
        send_file();

        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(4, 4);
        wav_bytes[POS_WAVE_END] = wav_bytes[POS_WAVE_END] ^ 8'h80;
        send_file();
        drain_decoder();
    endtask

    // Files that end early or declare more than they hold.
    task automatic test_short_files();
        // A file of one byte.
        put_byte(TAG_RIFF[31:24]);
        send_file();

        // Cut inside the fmt body, so its values are never taken.
        put_riff_head();
        put_fmt(2, BITS_16, 32'd48000, 16);
        while (wav_bytes.size() > 30)
            void'(wav_bytes.pop_back());
        send_file();

        // Ends on the last byte of the data header: no data byte arrives.
        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(32'hFFFF_FFFF, 0);
        send_file();

        // The largest declared data size, clipped to what arrives.
        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(32'hFFFF_FFFF, 5);
        send_file();

        // An unknown chunk of the largest size swallows the rest.
        put_riff_head();
        put_fmt(2, BITS_8, 32'd11025, 16);
        put_tag(TAG_LIST);
        put_le32(32'hFFFF_FFFF);
        repeat (10) put_byte(8'($urandom));
        send_file();
        drain_decoder();
    endtask

    // The receiver holds off for a long stretch while a long mono file keeps
    // coming, so the block must stall its input until requests drain.
    task automatic test_result_backlog();
        gap_odds = 0;
        stall_odds = 0;
        backlog_hold = 1'b1;
        put_riff_head();
        put_fmt(1, BITS_8, 32'd8000, 16);
        put_data(60, 60);
        send_file();
        drain_decoder();
    endtask

    // Random files, mostly well formed with random content and layout, some
    // with a faulty format, a flipped bit, a cut-off end, or pure noise.
    task automatic test_random_files(input int byte_budget, input bit with_gaps);
        int          sent;
        int          ch;
        int          bits;
        logic [31:0] rate;
        int          fbytes;
        int          dlen;
        logic [31:0] declared;
        sent = 0;
        while (sent < byte_budget)
        begin
            gap_odds   = with_gaps ? pick_odds() : 0;
            stall_odds = with_gaps ? pick_odds() : 0;
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 60))
                    put_byte(8'($urandom));
            end
            else
            begin
                ch = $urandom_range(1, MAX_CHANNELS);
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: ch = 0;
                        1: ch = MAX_CHANNELS + $urandom_range(1, 3);
                        default: ch = $urandom_range(0, 65535);
                    endcase
                end
                bits = $urandom_range(0, 1) ? 16 : 8;
                if ($urandom_range(0, 11) == 0)
                    bits = $urandom_range(0, 65535);
                rate = ($urandom_range(0, 14) == 0) ? 32'd0 : 32'($urandom);

                put_riff_head();
                if ($urandom_range(0, 3) == 0)
                    put_chunk($urandom, $urandom_range(0, 7));
                // An earlier fmt, either too short to count or replaced by the main fmt when one follows.
                if ($urandom_range(0, 4) == 0)
                    put_fmt(16'($urandom_range(1, MAX_CHANNELS)), BITS_8, $urandom,
                            $urandom_range(0, 1) ? $urandom_range(0, 15) : 16);
                if ($urandom_range(0, 19) != 0)
                    put_fmt(16'(ch), 16'(bits), rate,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : 16);
                if ($urandom_range(0, 5) == 0)
                    put_chunk($urandom, $urandom_range(0, 5));

                fbytes = ((bits == 8 || bits == 16) && ch >= 1 && ch <= MAX_CHANNELS) ?
                         (bits / 8) * ch : 2;
                dlen = $urandom_range(0, 12) * fbytes;
                if ($urandom_range(0, 3) == 0)
                    dlen += $urandom_range(1, fbytes);
                declared = dlen;
                case ($urandom_range(0, 9))
                    0: declared = 32'd0;
                    1: declared = 32'hFFFF_FFFF;
                    2: declared = dlen / 2;
                    default:
                    begin
                    end
                endcase
                put_data(declared, dlen);
                if ($urandom_range(0, 4) == 0)
                    put_chunk($urandom, $urandom_range(0, 4));

                if ($urandom_range(0, 9) == 0)
                    wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] ^=
                        8'(1 << $urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0)
                    dlen = $urandom_range(1, wav_bytes.size());
                else
                    dlen = wav_bytes.size();
                while (wav_bytes.size() > dlen)
                    void'(wav_bytes.pop_back());
            end
            sent += wav_bytes.size();
            send_file();
        end
        drain_decoder();
    endtask

    // Receiver: ready in random stall bursts, or one long hold-off when a
    // test asks for it; the hold-off is counted here in clock cycles.
    initial
    begin
        result_stream.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (backlog_hold)
            begin
                backlog_hold = 1'b0;
                result_stream.ready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge clk);
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                result_stream.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                result_stream.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Every result request taken is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (result_stream.valid && result_stream.ready)
        begin
            if (decoded_due.size() == 0)
            begin
                $error("result request with nothing owed: kind %0d, sample %0d",
                       result_stream.kind, result_stream.sample);
                mismatches++;
            end
            else
            begin
                owed = decoded_due.pop_front();
                compare_field("kind", 32'(owed.kind), 32'(result_stream.kind));
                compare_field("sample", 32'(owed.sample), 32'(result_stream.sample));
                compare_field("status_ok", 32'(owed.status_ok),
                              32'(result_stream.status_ok));
                compare_field("channel_count", 32'(owed.channel_count),
                              32'(result_stream.channel_count));
                compare_field("sample_bits", 32'(owed.sample_bits),
                              32'(result_stream.sample_bits));
                compare_field("sample_rate", owed.sample_rate, result_stream.sample_rate);
                compare_field("frame_count", owed.frame_count, result_stream.frame_count);
                compare_field("run_last", 32'(owed.run_last), 32'(result_stream.run_last));
            end
        end
    end

    // Watchdog: a long run of cycles in which neither side takes a request
    // means the decoder has hung.
    always @(posedge clk)
    begin
        if ((file_stream.valid && file_stream.ready) ||
            (result_stream.valid && result_stream.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        file_stream.valid      = 1'b0;
        file_stream.file_byte  = '0;
        file_stream.final_byte = 1'b0;
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        gap_odds   = 6;
        stall_odds = 6;
        test_extreme_samples();
        test_chunk_walk();
        test_format_faults();
        test_bad_tags();
        test_short_files();
        test_result_backlog();
        test_random_files(600, 1'b1);
        // The closing stretch runs flat out on both sides.
        test_random_files(200, 1'b0);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> wav_to_mono8_decoder.f
src/w2m8_pkg.sv
src/w2m8_in_if.sv
src/w2m8_out_if.sv
src/w2m8_div.sv
src/w2m8_parser.sv
src/wav_to_mono8_decoder.sv
src/w2m8_checker.sv
tb/sv/tb_wav_to_mono8_decoder.sv
